/* sv/tspr_pkg.sv */
// Shared types and constants for the tile and sprite pixel renderer.
// No dependencies; every other file refers to this package by scoped names.
package tspr_pkg;

    // Parameter defaults
    localparam int SCREEN_WIDTH_DEF     = 160;
    localparam int MAX_LINE_SPRITES_DEF = 10;
    localparam int SPRITE_ENTRIES_DEF   = 40;

    localparam int VRAM_AW = 13;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_VRAM_WR   = 2'd0,
        OP_SPRITE_WR = 2'd1,
        OP_LINE      = 2'd2,
        OP_PIXEL     = 2'd3
    } op_t;

    // Register indexes
    typedef enum logic [2:0] {
        REG_LCDC = 3'd0,
        REG_SCX  = 3'd1,
        REG_SCY  = 3'd2,
        REG_WX   = 3'd3,
        REG_WY   = 3'd4,
        REG_BGP  = 3'd5,
        REG_OBP0 = 3'd6,
        REG_OBP1 = 3'd7
    } reg_idx_t;

    localparam logic [7:0] LCDC_RESET = 8'h91;
    localparam logic [7:0] BGP_RESET  = 8'hFC;
    localparam logic [7:0] OBP_RESET  = 8'hFF;

    // Datapath steps
    typedef enum logic [4:0] {
        ST_NONE,
        ST_ACCEPT,
        ST_SCAN_INIT,
        ST_SCAN_RDY,
        ST_SCAN_RDX,
        ST_SCAN_EVAL,
        ST_RND_INIT,
        ST_MAP,
        ST_TID,
        ST_TLO,
        ST_THI,
        ST_SP_Y,
        ST_SP_X,
        ST_SP_T,
        ST_SP_A,
        ST_SP_CHK,
        ST_SP_LO,
        ST_SP_HI,
        ST_OUT
    } step_t;

    typedef struct packed {
        step_t step;
        logic  win;
    } cmd_t;

    typedef struct packed {
        logic col_off;
        logic bg_on;
        logic win_hit;
        logic sprites_on;
        logic sp_any;
        logic scan_last;
        logic sp_last;
        logic out_busy;
    } sts_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SC_INIT,
        S_SC_Y,
        S_SC_X,
        S_SC_EV,
        S_RN_INIT,
        S_BG_MAP,
        S_BG_ID,
        S_BG_LO,
        S_BG_HI,
        S_WN_MAP,
        S_WN_ID,
        S_WN_LO,
        S_WN_HI,
        S_SP_Y,
        S_SP_X,
        S_SP_T,
        S_SP_A,
        S_SP_CHK,
        S_SP_LO,
        S_SP_HI,
        S_OUT
    } state_t;

    // Shade for a colour index: 3 minus the palette field
    function automatic logic [1:0] shade_of(input logic [7:0] pal, input logic [1:0] idx);
        logic [1:0] f;
        case (idx)
            2'd0:    f = pal[1:0];
            2'd1:    f = pal[3:2];
            2'd2:    f = pal[5:4];
            default: f = pal[7:6];
        endcase
        return ~f;
    endfunction

endpackage

/* sv/tspr_ctrl.sv */
// Sequencer for the tile and sprite pixel renderer.
// Depends on tspr_pkg; drives tspr_dp through cmd_t and reads back sts_t.
module tspr_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       opcode,
    output logic             in_stall,
    input  tspr_pkg::sts_t   sts,
    output tspr_pkg::cmd_t   cmd
);

    tspr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tspr_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tspr_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (tspr_pkg::op_t'(opcode))
                        tspr_pkg::OP_LINE:  state_next = tspr_pkg::S_SC_INIT;
                        tspr_pkg::OP_PIXEL: state_next = tspr_pkg::S_RN_INIT;
                        default:            state_next = tspr_pkg::S_IDLE;
                    endcase
                end
            end
            tspr_pkg::S_SC_INIT:
                state_next = sts.sprites_on ? tspr_pkg::S_SC_Y : tspr_pkg::S_IDLE;
            tspr_pkg::S_SC_Y:  state_next = tspr_pkg::S_SC_X;
            tspr_pkg::S_SC_X:  state_next = tspr_pkg::S_SC_EV;
            tspr_pkg::S_SC_EV:
                state_next = sts.scan_last ? tspr_pkg::S_IDLE : tspr_pkg::S_SC_Y;
            tspr_pkg::S_RN_INIT:
            begin
                if (sts.col_off)
                    state_next = tspr_pkg::S_OUT;
                else if (sts.bg_on)
                    state_next = tspr_pkg::S_BG_MAP;
                else if (sts.win_hit)
                    state_next = tspr_pkg::S_WN_MAP;
                else if (sts.sp_any)
                    state_next = tspr_pkg::S_SP_Y;
                else
                    state_next = tspr_pkg::S_OUT;
            end
            tspr_pkg::S_BG_MAP: state_next = tspr_pkg::S_BG_ID;
            tspr_pkg::S_BG_ID:  state_next = tspr_pkg::S_BG_LO;
            tspr_pkg::S_BG_LO:  state_next = tspr_pkg::S_BG_HI;
            tspr_pkg::S_BG_HI:
            begin
                if (sts.win_hit)
                    state_next = tspr_pkg::S_WN_MAP;
                else if (sts.sp_any)
                    state_next = tspr_pkg::S_SP_Y;
                else
                    state_next = tspr_pkg::S_OUT;
            end
            tspr_pkg::S_WN_MAP: state_next = tspr_pkg::S_WN_ID;
            tspr_pkg::S_WN_ID:  state_next = tspr_pkg::S_WN_LO;
            tspr_pkg::S_WN_LO:  state_next = tspr_pkg::S_WN_HI;
            tspr_pkg::S_WN_HI:
                state_next = sts.sp_any ? tspr_pkg::S_SP_Y : tspr_pkg::S_OUT;
            tspr_pkg::S_SP_Y:   state_next = tspr_pkg::S_SP_X;
            tspr_pkg::S_SP_X:   state_next = tspr_pkg::S_SP_T;
            tspr_pkg::S_SP_T:   state_next = tspr_pkg::S_SP_A;
            tspr_pkg::S_SP_A:   state_next = tspr_pkg::S_SP_CHK;
            tspr_pkg::S_SP_CHK: state_next = tspr_pkg::S_SP_LO;
            tspr_pkg::S_SP_LO:  state_next = tspr_pkg::S_SP_HI;
            tspr_pkg::S_SP_HI:
                state_next = sts.sp_last ? tspr_pkg::S_OUT : tspr_pkg::S_SP_Y;
            tspr_pkg::S_OUT:
                state_next = sts.out_busy ? tspr_pkg::S_OUT : tspr_pkg::S_IDLE;
            default: state_next = tspr_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_stall = (state_reg != tspr_pkg::S_IDLE);
        cmd.win  = 1'b0;
        cmd.step = tspr_pkg::ST_NONE;
        case (state_reg)
            tspr_pkg::S_IDLE:
                cmd.step = in_valid ? tspr_pkg::ST_ACCEPT : tspr_pkg::ST_NONE;
            tspr_pkg::S_SC_INIT: cmd.step = tspr_pkg::ST_SCAN_INIT;
            tspr_pkg::S_SC_Y:    cmd.step = tspr_pkg::ST_SCAN_RDY;
            tspr_pkg::S_SC_X:    cmd.step = tspr_pkg::ST_SCAN_RDX;
            tspr_pkg::S_SC_EV:   cmd.step = tspr_pkg::ST_SCAN_EVAL;
            tspr_pkg::S_RN_INIT: cmd.step = tspr_pkg::ST_RND_INIT;
            tspr_pkg::S_BG_MAP:  cmd.step = tspr_pkg::ST_MAP;
            tspr_pkg::S_BG_ID:   cmd.step = tspr_pkg::ST_TID;
            tspr_pkg::S_BG_LO:   cmd.step = tspr_pkg::ST_TLO;
            tspr_pkg::S_BG_HI:   cmd.step = tspr_pkg::ST_THI;
            tspr_pkg::S_WN_MAP:
            begin
                cmd.step = tspr_pkg::ST_MAP;
                cmd.win  = 1'b1;
            end
            tspr_pkg::S_WN_ID:
            begin
                cmd.step = tspr_pkg::ST_TID;
                cmd.win  = 1'b1;
            end
            tspr_pkg::S_WN_LO:
            begin
                cmd.step = tspr_pkg::ST_TLO;
                cmd.win  = 1'b1;
            end
            tspr_pkg::S_WN_HI:
            begin
                cmd.step = tspr_pkg::ST_THI;
                cmd.win  = 1'b1;
            end
            tspr_pkg::S_SP_Y:    cmd.step = tspr_pkg::ST_SP_Y;
            tspr_pkg::S_SP_X:    cmd.step = tspr_pkg::ST_SP_X;
            tspr_pkg::S_SP_T:    cmd.step = tspr_pkg::ST_SP_T;
            tspr_pkg::S_SP_A:    cmd.step = tspr_pkg::ST_SP_A;
            tspr_pkg::S_SP_CHK:  cmd.step = tspr_pkg::ST_SP_CHK;
            tspr_pkg::S_SP_LO:   cmd.step = tspr_pkg::ST_SP_LO;
            tspr_pkg::S_SP_HI:   cmd.step = tspr_pkg::ST_SP_HI;
            tspr_pkg::S_OUT:
                cmd.step = sts.out_busy ? tspr_pkg::ST_NONE : tspr_pkg::ST_OUT;
            default: cmd.step = tspr_pkg::ST_NONE;
        endcase
    end

endmodule

/* sv/tspr_dp.sv */
// Datapath of the tile and sprite pixel renderer: memories, sprite list,
// configuration registers, pixel arithmetic and output register. Uses tspr_pkg.
module tspr_dp
#(
    parameter int SCREEN_WIDTH     = tspr_pkg::SCREEN_WIDTH_DEF,
    parameter int MAX_LINE_SPRITES = tspr_pkg::MAX_LINE_SPRITES_DEF,
    parameter int SPRITE_ENTRIES   = tspr_pkg::SPRITE_ENTRIES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tspr_pkg::cmd_t                cmd,
    output tspr_pkg::sts_t                sts,
    input  logic [1:0]                    opcode,
    input  logic [tspr_pkg::VRAM_AW-1:0]  mem_address,
    input  logic [7:0]                    write_data,
    input  logic [7:0]                    line_number,
    input  logic [7:0]                    pixel_column,
    input  logic                          cfg_valid,
    input  logic [2:0]                    cfg_index,
    input  logic [7:0]                    cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    pixel_shade,
    output logic [7:0]                    out_column,
    output logic [7:0]                    out_line
);

    localparam int IW   = (SPRITE_ENTRIES > 1) ? $clog2(SPRITE_ENTRIES) : 1;
    localparam int SAW  = IW + 2;
    localparam int SDEP = SPRITE_ENTRIES * 4;
    localparam int CW   = $clog2(MAX_LINE_SPRITES + 1);
    localparam int LW   = (MAX_LINE_SPRITES > 1) ? $clog2(MAX_LINE_SPRITES) : 1;
    localparam int VDEP = 1 << tspr_pkg::VRAM_AW;

    // Memories
    logic [7:0] vram_mem [VDEP];
    logic [7:0] spr_mem  [SDEP];
    logic [7:0] vram_q;
    logic [7:0] spr_q;
    logic [tspr_pkg::VRAM_AW-1:0] vram_raddr;
    logic [SAW-1:0]               spr_raddr;

    // Configuration
    logic [7:0] lcdc_reg, scx_reg, scy_reg, wx_reg, wy_reg, bgp_reg, obp0_reg, obp1_reg;

    // Working registers
    logic [7:0]    col_reg,   col_next;
    logic [7:0]    line_reg,  line_next;
    logic [IW-1:0] scan_i_reg, scan_i_next;
    logic [7:0]    y_reg,     y_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] k_reg,     k_next;
    logic [IW-1:0] list_id_reg [MAX_LINE_SPRITES];
    logic [IW-1:0] list_id_next [MAX_LINE_SPRITES];
    logic [7:0]    list_x_reg  [MAX_LINE_SPRITES];
    logic [7:0]    list_x_next [MAX_LINE_SPRITES];
    logic [1:0]    shade_reg, shade_next;
    logic [1:0]    bidx_reg,  bidx_next;
    logic [tspr_pkg::VRAM_AW-1:0] addr_reg, addr_next;
    logic [7:0]    lo_reg,    lo_next;
    logic [7:0]    sx_reg,    sx_next;
    logic [7:0]    tile_reg,  tile_next;
    logic [7:0]    attr_reg,  attr_next;
    logic          draw_reg,  draw_next;
    logic [2:0]    scol_reg,  scol_next;
    logic          out_valid_reg;
    logic [1:0]    out_shade_reg;
    logic [7:0]    out_col_reg, out_line_reg;

    // Layer coordinates
    logic [7:0]  lyy, lxx;
    logic        map_sel;
    logic [tspr_pkg::VRAM_AW-1:0] map_addr, tile_row_addr;
    logic [1:0]  tidx;

    // Sprite arithmetic
    logic [IW-1:0] cur_sprite;
    logic [7:0]    srow;
    logic          tall, srow_ok, sdx_ok, sdraw;
    logic [9:0]    sdx;
    logic [3:0]    srowf;
    logic [7:0]    stile;
    logic [tspr_pkg::VRAM_AW-1:0] sp_addr;
    logic [1:0]    sidx;
    logic [7:0]    spal;

    // Scan arithmetic
    logic [9:0] scan_d;
    logic       scan_hit, scan_full, scan_take;

    always_comb
    begin
        tall = lcdc_reg[2];
        if (cmd.win)
        begin
            lyy     = line_reg - wy_reg;
            lxx     = col_reg + 8'd7 - wx_reg;
            map_sel = lcdc_reg[6];
        end
        else
        begin
            lyy     = line_reg + scy_reg;
            lxx     = col_reg + scx_reg;
            map_sel = lcdc_reg[3];
        end
        map_addr      = {2'b11, map_sel, lyy[7:3], lxx[7:3]};
        // Signed tile addressing puts indices below 128 at offset 0x1000
        tile_row_addr = {~lcdc_reg[4] & ~vram_q[7], vram_q, lyy[2:0], 1'b0};
        tidx          = {vram_q[3'd7 - lxx[2:0]], lo_reg[3'd7 - lxx[2:0]]};

        cur_sprite = list_id_reg[k_reg[LW-1:0]];
        srow       = line_reg + 8'd16 - y_reg;
        srow_ok    = tall ? (srow < 8'd16) : (srow < 8'd8);
        sdx        = {2'b00, col_reg} + 10'd8 - {2'b00, sx_reg};
        sdx_ok     = (sdx[9:3] == 7'd0);
        sdraw      = (sx_reg != 8'd0) && srow_ok && sdx_ok;
        if (spr_q[6])
            srowf = tall ? ~srow[3:0] : {1'b0, ~srow[2:0]};
        else
            srowf = srow[3:0];
        stile   = tall ? {tile_reg[7:1], 1'b0} : tile_reg;
        sp_addr = {1'b0, stile, 4'b0000} + {8'd0, srowf, 1'b0};
        sidx    = {vram_q[3'd7 - scol_reg], lo_reg[3'd7 - scol_reg]};
        spal    = attr_reg[4] ? obp1_reg : obp0_reg;

        scan_d    = {2'b00, line_reg} + 10'd16 - {2'b00, y_reg};
        scan_hit  = !scan_d[9] && (scan_d < (tall ? 10'd16 : 10'd8));
        scan_full = (count_reg == CW'(MAX_LINE_SPRITES));
        scan_take = scan_hit && !(scan_full && (spr_q >= list_x_reg[MAX_LINE_SPRITES-1]));
    end

    // Read addresses
    always_comb
    begin
        case (cmd.step)
            tspr_pkg::ST_MAP:    vram_raddr = map_addr;
            tspr_pkg::ST_TID:    vram_raddr = tile_row_addr;
            tspr_pkg::ST_TLO:    vram_raddr = addr_reg | tspr_pkg::VRAM_AW'(1);
            tspr_pkg::ST_SP_CHK: vram_raddr = sp_addr;
            tspr_pkg::ST_SP_LO:  vram_raddr = addr_reg | tspr_pkg::VRAM_AW'(1);
            default:             vram_raddr = '0;
        endcase
        case (cmd.step)
            tspr_pkg::ST_SCAN_RDY: spr_raddr = {scan_i_reg, 2'd0};
            tspr_pkg::ST_SCAN_RDX: spr_raddr = {scan_i_reg, 2'd1};
            tspr_pkg::ST_SP_Y:     spr_raddr = {cur_sprite, 2'd0};
            tspr_pkg::ST_SP_X:     spr_raddr = {cur_sprite, 2'd1};
            tspr_pkg::ST_SP_T:     spr_raddr = {cur_sprite, 2'd2};
            tspr_pkg::ST_SP_A:     spr_raddr = {cur_sprite, 2'd3};
            default:               spr_raddr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step == tspr_pkg::ST_ACCEPT && tspr_pkg::op_t'(opcode) == tspr_pkg::OP_VRAM_WR)
        begin
            vram_mem[mem_address] <= write_data;
        end
        vram_q <= vram_mem[vram_raddr];
    end

    always_ff @(posedge clk)
    begin
        // Drop sprite writes beyond the table
        if (cmd.step == tspr_pkg::ST_ACCEPT &&
            tspr_pkg::op_t'(opcode) == tspr_pkg::OP_SPRITE_WR &&
            {1'b0, mem_address} < 14'(SDEP))
        begin
            spr_mem[mem_address[SAW-1:0]] <= write_data;
        end
        spr_q <= spr_mem[spr_raddr];
    end

    // Next values
    always_comb
    begin
        col_next    = col_reg;
        line_next   = line_reg;
        scan_i_next = scan_i_reg;
        y_next      = y_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        shade_next  = shade_reg;
        bidx_next   = bidx_reg;
        addr_next   = addr_reg;
        lo_next     = lo_reg;
        sx_next     = sx_reg;
        tile_next   = tile_reg;
        attr_next   = attr_reg;
        draw_next   = draw_reg;
        scol_next   = scol_reg;
        for (int j = 0; j < MAX_LINE_SPRITES; j++)
        begin
            list_id_next[j] = list_id_reg[j];
            list_x_next[j]  = list_x_reg[j];
        end
        case (cmd.step)
            tspr_pkg::ST_ACCEPT:
            begin
                col_next = pixel_column;
                if (tspr_pkg::op_t'(opcode) == tspr_pkg::OP_LINE)
                    line_next = line_number;
            end
            tspr_pkg::ST_SCAN_INIT:
            begin
                count_next  = '0;
                scan_i_next = '0;
            end
            tspr_pkg::ST_SCAN_RDX: y_next = spr_q;
            tspr_pkg::ST_SCAN_EVAL:
            begin
                scan_i_next = scan_i_reg + IW'(1);
                if (scan_take)
                begin
                    // Insert behind every listed entry with X not above this one
                    for (int j = 0; j < MAX_LINE_SPRITES; j++)
                    begin
                        if (CW'(j) < count_reg && list_x_reg[j] <= spr_q)
                        begin
                            list_id_next[j] = list_id_reg[j];
                            list_x_next[j]  = list_x_reg[j];
                        end
                        else if (j == 0 || (CW'(j - 1) < count_reg &&
                                 list_x_reg[(j > 0) ? j - 1 : 0] <= spr_q))
                        begin
                            list_id_next[j] = scan_i_reg;
                            list_x_next[j]  = spr_q;
                        end
                        else
                        begin
                            list_id_next[j] = list_id_reg[(j > 0) ? j - 1 : 0];
                            list_x_next[j]  = list_x_reg[(j > 0) ? j - 1 : 0];
                        end
                    end
                    if (!scan_full)
                        count_next = count_reg + CW'(1);
                end
            end
            tspr_pkg::ST_RND_INIT:
            begin
                shade_next = 2'd3;
                bidx_next  = 2'd0;
                k_next     = '0;
            end
            tspr_pkg::ST_TID: addr_next = tile_row_addr;
            tspr_pkg::ST_TLO: lo_next   = vram_q;
            tspr_pkg::ST_THI:
            begin
                bidx_next  = tidx;
                shade_next = tspr_pkg::shade_of(bgp_reg, tidx);
            end
            tspr_pkg::ST_SP_X: y_next    = spr_q;
            tspr_pkg::ST_SP_T: sx_next   = spr_q;
            tspr_pkg::ST_SP_A: tile_next = spr_q;
            tspr_pkg::ST_SP_CHK:
            begin
                attr_next = spr_q;
                draw_next = sdraw;
                scol_next = spr_q[5] ? ~sdx[2:0] : sdx[2:0];
                addr_next = sp_addr;
            end
            tspr_pkg::ST_SP_LO: lo_next = vram_q;
            tspr_pkg::ST_SP_HI:
            begin
                k_next = k_reg + CW'(1);
                if (draw_reg && sidx != 2'd0 && !(attr_reg[7] && bidx_reg != 2'd0))
                    shade_next = tspr_pkg::shade_of(spal, sidx);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcdc_reg      <= tspr_pkg::LCDC_RESET;
            scx_reg       <= '0;
            scy_reg       <= '0;
            wx_reg        <= '0;
            wy_reg        <= '0;
            bgp_reg       <= tspr_pkg::BGP_RESET;
            obp0_reg      <= tspr_pkg::OBP_RESET;
            obp1_reg      <= tspr_pkg::OBP_RESET;
            line_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (tspr_pkg::reg_idx_t'(cfg_index))
                    tspr_pkg::REG_LCDC: lcdc_reg <= cfg_data;
                    tspr_pkg::REG_SCX:  scx_reg  <= cfg_data;
                    tspr_pkg::REG_SCY:  scy_reg  <= cfg_data;
                    tspr_pkg::REG_WX:   wx_reg   <= cfg_data;
                    tspr_pkg::REG_WY:   wy_reg   <= cfg_data;
                    tspr_pkg::REG_BGP:  bgp_reg  <= cfg_data;
                    tspr_pkg::REG_OBP0: obp0_reg <= cfg_data;
                    tspr_pkg::REG_OBP1: obp1_reg <= cfg_data;
                    default: ;
                endcase
            end
            line_reg  <= line_next;
            count_reg <= count_next;
            if (cmd.step == tspr_pkg::ST_OUT)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg    <= col_next;
        scan_i_reg <= scan_i_next;
        y_reg      <= y_next;
        k_reg      <= k_next;
        shade_reg  <= shade_next;
        bidx_reg   <= bidx_next;
        addr_reg   <= addr_next;
        lo_reg     <= lo_next;
        sx_reg     <= sx_next;
        tile_reg   <= tile_next;
        attr_reg   <= attr_next;
        draw_reg   <= draw_next;
        scol_reg   <= scol_next;
        for (int j = 0; j < MAX_LINE_SPRITES; j++)
        begin
            list_id_reg[j] <= list_id_next[j];
            list_x_reg[j]  <= list_x_next[j];
        end
        if (cmd.step == tspr_pkg::ST_OUT)
        begin
            out_shade_reg <= shade_reg;
            out_col_reg   <= col_reg;
            out_line_reg  <= line_reg;
        end
    end

    always_comb
    begin
        sts.col_off    = ({1'b0, col_reg} >= 9'(SCREEN_WIDTH));
        sts.bg_on      = lcdc_reg[7] & lcdc_reg[0];
        sts.win_hit    = lcdc_reg[5] && (line_reg >= wy_reg) &&
                         (({1'b0, col_reg} + 9'd7) >= {1'b0, wx_reg});
        sts.sprites_on = lcdc_reg[1];
        sts.sp_any     = lcdc_reg[1] && (count_reg != '0);
        sts.scan_last  = (scan_i_reg == IW'(SPRITE_ENTRIES - 1));
        sts.sp_last    = ((k_reg + CW'(1)) >= count_reg);
        sts.out_busy   = out_valid_reg & out_stall;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_shade = out_shade_reg;
    assign out_column  = out_col_reg;
    assign out_line    = out_line_reg;

endmodule

/* sv/tile_sprite_pixel_renderer.sv */
// Top level of the tile and sprite pixel renderer.
// Depends on tspr_pkg, tspr_ctrl and tspr_dp.
//
// Items enter one at a time on the valid/stall input channel. Video RAM and
// sprite RAM writes produce no transfer on the output. A start-line item
// scans every sprite entry through the single sprite RAM read port, reading
// its Y and X bytes and then evaluating it; with sprites disabled it clears
// the sprite list and scans nothing. A render item fetches a map byte and
// two tile bytes for the background and again for the window, each only
// when that layer is on, then four attribute bytes and two tile bytes for
// each listed sprite, one after another through the one video RAM and one
// sprite RAM port. The pixel lands in an output register and the block
// takes the next item while that result waits; it only holds a new result
// back while the previous one is still stalled. Configuration writes are
// always ready and should be issued only while the block is idle. Memory
// contents are undefined until written.
module tile_sprite_pixel_renderer
#(
    parameter int SCREEN_WIDTH     = tspr_pkg::SCREEN_WIDTH_DEF,
    parameter int MAX_LINE_SPRITES = tspr_pkg::MAX_LINE_SPRITES_DEF,
    parameter int SPRITE_ENTRIES   = tspr_pkg::SPRITE_ENTRIES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Item input
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    opcode,
    input  logic [tspr_pkg::VRAM_AW-1:0]  mem_address,
    input  logic [7:0]                    write_data,
    input  logic [7:0]                    line_number,
    input  logic [7:0]                    pixel_column,
    // Result output
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    pixel_shade,
    output logic [7:0]                    out_column,
    output logic [7:0]                    out_line,
    // Configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [7:0]                    cfg_data
);

    tspr_pkg::cmd_t cmd;
    tspr_pkg::sts_t sts;

    // Registers accept a transfer on any cycle
    assign cfg_ready = 1'b1;

    tspr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    tspr_dp
    #(
        .SCREEN_WIDTH     (SCREEN_WIDTH),
        .MAX_LINE_SPRITES (MAX_LINE_SPRITES),
        .SPRITE_ENTRIES   (SPRITE_ENTRIES)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .mem_address  (mem_address),
        .write_data   (write_data),
        .line_number  (line_number),
        .pixel_column (pixel_column),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_shade  (pixel_shade),
        .out_column   (out_column),
        .out_line     (out_line)
    );

endmodule
